@@ rtl/rcfe_pkg.sv @@
`default_nettype none

package rcfe_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  localparam logic [7:0] HDR_BYTE = 8'h0F;
  localparam logic [7:0] FLAG_LOSS = 8'h04;
  localparam logic [7:0] FLAG_FAILSAFE = 8'h08;
  localparam logic [7:0] FOOT_BYTE = 8'h00;

  localparam logic [10:0] PW_LOW = 11'd990;
  localparam logic [10:0] PW_HIGH = 11'd2010;
  localparam logic [10:0] OUT_LOW = 11'd173;

  // (x - 990) * 1638 / 1020 equals (x - 990) * 273 / 170; the division by 170
  // is a multiplication by ceil(2^36 / 170), exact over the whole input range.
  localparam logic [8:0] SCALE_NUM = 9'd273;
  localparam logic [28:0] RECIP_170 = 29'd404232217;
  localparam int RECIP_SHIFT = 36;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);
  localparam int OCC_W = QCW + 1;

  typedef struct packed {
    logic [10:0] value;
    logic first;
    logic last;
    logic loss;
    logic fsafe;
  } item_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DATA,
    PH_FLAGS,
    PH_FOOT
  } phase_t;

endpackage

`default_nettype wire

@@ rtl/rcfe_front.sv @@
`default_nettype none

module rcfe_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire logic [10:0]        pulse_width,
  input  wire logic               signal_loss,
  input  wire logic               failsafe,
  output rcfe_pkg::item_t         item,
  output logic                    item_valid,
  output logic [1:0]              inflight
);
  import rcfe_pkg::*;

  logic [CH_W-1:0] ch;
  logic            a_valid;
  logic [18:0]     a_prod;
  item_t           a_item;
  logic            b_valid;
  logic [10:0]     b_quot;
  item_t           b_item;
  logic [10:0]     clamped;
  logic [9:0]      offset;
  logic [47:0]     recip_prod;

  always_comb begin
    priority if (pulse_width < PW_LOW) begin
      clamped = PW_LOW;
    end else if (pulse_width > PW_HIGH) begin
      clamped = PW_HIGH;
    end else begin
      clamped = pulse_width;
    end
    offset = 10'(clamped - PW_LOW);
    recip_prod = 48'(a_prod) * 48'(RECIP_170);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= take;
      b_valid <= a_valid;
      if (take) begin
        ch <= (ch == CH_LAST) ? '0 : ch + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_prod <= 19'(offset) * 19'(SCALE_NUM);
      a_item.value <= '0;
      a_item.first <= (ch == '0);
      a_item.last <= (ch == CH_LAST);
      a_item.loss <= signal_loss;
      a_item.fsafe <= failsafe;
    end
    if (a_valid) begin
      b_quot <= recip_prod[RECIP_SHIFT+10:RECIP_SHIFT];
      b_item <= a_item;
    end
  end

  always_comb begin
    item = b_item;
    item.value = b_quot + OUT_LOW;
    item_valid = b_valid;
    inflight = {1'b0, a_valid} + {1'b0, b_valid};
  end

endmodule

`default_nettype wire

@@ rtl/rcfe_fifo.sv @@
`default_nettype none

module rcfe_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr,
  input  wire rcfe_pkg::item_t    wr_item,
  input  wire logic               rd,
  output rcfe_pkg::item_t         rd_item,
  output logic                    rd_valid,
  output logic [rcfe_pkg::QCW-1:0] count
);
  import rcfe_pkg::*;

  item_t          entries [QDEPTH];
  logic [QAW-1:0] head;
  logic [QAW-1:0] tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        tail <= tail + 1'b1;
      end
      if (rd) begin
        head <= head + 1'b1;
      end
      count <= count + QCW'(wr) - QCW'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[tail] <= wr_item;
    end
  end

  assign rd_item = entries[head];
  assign rd_valid = (count != '0);

endmodule

`default_nettype wire

@@ rtl/rcfe_back.sv @@
`default_nettype none

module rcfe_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rcfe_pkg::item_t    q_item,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire logic               pop,
  output logic                    empty,
  output logic [7:0]              frame_byte,
  output logic                    frame_end
);
  import rcfe_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [17:0] acc;
  logic [17:0] acc_next;
  logic [4:0]  pend;
  logic [4:0]  pend_next;
  logic        last;
  logic        last_next;
  logic [7:0]  flags;
  logic [7:0]  flags_next;
  logic        out_valid;
  logic        slot_free;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_end;
  logic [17:0] merged;

  assign slot_free = !out_valid || pop;
  assign merged = acc | (18'(q_item.value) << pend[2:0]);

  always_comb begin
    phase_next = phase;
    if (slot_free) begin
      unique case (phase)
        PH_IDLE: begin
          if (q_valid) begin
            if (q_item.first || q_item.last || (pend + 5'd3 >= 5'd8)) begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          priority if (pend >= 5'd8) begin
            if (!last && (pend - 5'd8 < 5'd8)) begin
              phase_next = PH_IDLE;
            end
          end else if (!last) begin
            phase_next = PH_IDLE;
          end else if (pend != '0) begin
            phase_next = PH_FLAGS;
          end else begin
            phase_next = PH_FOOT;
          end
        end
        PH_FLAGS: phase_next = PH_FOOT;
        PH_FOOT: phase_next = PH_IDLE;
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    acc_next = acc;
    pend_next = pend;
    last_next = last;
    flags_next = flags;
    emit = 1'b0;
    emit_byte = FOOT_BYTE;
    emit_end = 1'b0;
    q_pop = 1'b0;
    if (slot_free) begin
      unique case (phase)
        PH_IDLE: begin
          if (q_valid) begin
            q_pop = 1'b1;
            emit = 1'b1;
            last_next = q_item.last;
            flags_next = (q_item.loss ? FLAG_LOSS : 8'h00) |
                         (q_item.fsafe ? FLAG_FAILSAFE : 8'h00);
            if (q_item.first) begin
              emit_byte = HDR_BYTE;
              acc_next = merged;
              pend_next = pend + 5'd11;
            end else begin
              emit_byte = merged[7:0];
              acc_next = merged >> 8;
              pend_next = pend + 5'd3;
            end
          end
        end
        PH_DATA: begin
          priority if (pend >= 5'd8) begin
            emit = 1'b1;
            emit_byte = acc[7:0];
            acc_next = acc >> 8;
            pend_next = pend - 5'd8;
          end else if (!last) begin
            emit = 1'b0;
          end else if (pend != '0) begin
            emit = 1'b1;
            emit_byte = acc[7:0];
            acc_next = '0;
            pend_next = '0;
          end else begin
            emit = 1'b1;
            emit_byte = flags;
          end
        end
        PH_FLAGS: begin
          emit = 1'b1;
          emit_byte = flags;
        end
        PH_FOOT: begin
          emit = 1'b1;
          emit_byte = FOOT_BYTE;
          emit_end = 1'b1;
          acc_next = '0;
          pend_next = '0;
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      acc <= '0;
      pend <= '0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      acc <= acc_next;
      pend <= pend_next;
      if (slot_free) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    last <= last_next;
    flags <= flags_next;
    if (slot_free && emit) begin
      frame_byte <= emit_byte;
      frame_end <= emit_end;
    end
  end

  assign empty = !out_valid;

endmodule

`default_nettype wire

@@ rtl/rc_channel_frame_encoder.sv @@
// Radio-control channel frame encoder.
// Input queue side: present one channel request (pulse_width, signal_loss,
// failsafe) with push; it is taken at a clock edge where push is high and
// full is low. Channels arrive in order, 16 per frame; the flags are used
// only with the last channel of a frame.
// Output queue side: the oldest frame byte sits on frame_byte/frame_end
// while empty is low and is taken at an edge where pop is high. A frame is
// header 0x0F, 22 packed payload bytes, a flags byte and a 0x00 footer that
// carries frame_end.
// Latency: the first byte caused by a request appears once it has passed
// the second scaling stage, the queue write and the packer's output
// register.
// Throughput: the packer sends one byte per cycle while requests are queued
// and the receiver does not stall; a frame of 16 requests is 25 bytes. A
// four-entry queue lets the scaling pipeline take requests in consecutive
// cycles until it fills.
// Reset clears the channel count, the queue and the bit accumulator, so the
// next request starts a new frame. When the receiver stalls, the waiting
// byte holds, the packer stops, and full rises once the queue and the
// scaling stages hold four requests.
`default_nettype none

module rc_channel_frame_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [10:0] pulse_width,
  input  wire logic        signal_loss,
  input  wire logic        failsafe,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       frame_byte,
  output logic             frame_end
);
  import rcfe_pkg::*;

  item_t            f_item;
  logic             f_valid;
  logic [1:0]       inflight;
  item_t            q_item;
  logic             q_valid;
  logic             q_pop;
  logic [QCW-1:0]   q_count;
  logic [OCC_W-1:0] occupancy;
  logic             take;

  assign occupancy = OCC_W'(q_count) + OCC_W'(inflight);
  assign full = (occupancy >= OCC_W'(QDEPTH));
  assign take = push && !full;

  rcfe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .pulse_width (pulse_width),
    .signal_loss (signal_loss),
    .failsafe    (failsafe),
    .item        (f_item),
    .item_valid  (f_valid),
    .inflight    (inflight)
  );

  rcfe_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (f_valid),
    .wr_item  (f_item),
    .rd       (q_pop),
    .rd_item  (q_item),
    .rd_valid (q_valid),
    .count    (q_count)
  );

  rcfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .frame_byte (frame_byte),
    .frame_end  (frame_end)
  );

`ifndef SYNTHESIS
  a_occupancy_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(QDEPTH))
    else $error("queue occupancy exceeds its depth");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("packer read an empty queue");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    (f_valid && !q_pop) |-> (q_count < QCW'(QDEPTH)))
    else $error("scaled request written into a full queue");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (q_count == '0 && empty))
    else $error("queue or output not clear after reset");
`endif

endmodule

`default_nettype wire
